FILE: hw/rtl/cscm_pkg.sv
package cscm_pkg;

  // field widths
  localparam int REV_W   = 32;
  localparam int DT_W    = 16;
  localparam int CIRC_W  = 16;
  localparam int QUO_W   = 32;
  localparam int PROD_W  = REV_W + CIRC_W;
  // 1/1024 s time base: multiply by 1024 is a left shift
  localparam int TIME_SHIFT = 10;
  localparam int STEP_CNT_W = $clog2(QUO_W);

  localparam logic [CIRC_W-1:0] CIRC_RESET = 16'd2096;

  // byte positions inside a packet
  localparam logic [3:0] POS_FLAGS       = 4'd0;
  localparam logic [3:0] POS_MAX         = 4'd15;
  localparam logic [3:0] POS_WREV_LAST   = 4'd4;
  localparam logic [3:0] POS_WTIME_LO    = 4'd5;
  localparam logic [3:0] POS_WTIME_HI    = 4'd6;
  localparam logic [3:0] CRANK_AT_WHEEL  = 4'd7;
  localparam logic [3:0] CRANK_AT_NONE   = 4'd1;
  // last byte position a group needs to be complete
  localparam logic [3:0] WHEEL_END       = 4'd6;
  localparam logic [3:0] CRANK_END_WHEEL = 4'd10;
  localparam logic [3:0] CRANK_END_NONE  = 4'd4;

  localparam int FLAG_WHEEL = 0;
  localparam int FLAG_CRANK = 1;

  // offset of a byte inside the crank group
  localparam logic [1:0] CRANK_REV_LO  = 2'd0;
  localparam logic [1:0] CRANK_REV_HI  = 2'd1;
  localparam logic [1:0] CRANK_TIME_LO = 2'd2;
  localparam logic [1:0] CRANK_TIME_HI = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_MUL,
    ST_CHECK,
    ST_DIV,
    ST_WAIT
  } cscm_state_t;

  typedef struct packed {
    logic load;   // take rev and time deltas
    logic mul;    // register delta * circumference
    logic prime;  // seed remainder and dividend
    logic step;   // one restoring division step
  } cscm_ctrl_t;

  typedef struct packed {
    logic dt_zero;
    logic ovf;     // quotient would not fit 32 bits
    logic last;    // final division step
  } cscm_sts_t;

endpackage

FILE: hw/rtl/cscm_pkt_if.sv
interface cscm_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: hw/rtl/cscm_meas_if.sv
interface cscm_meas_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  valid_flags;
  logic [31:0] wheel_revs;
  logic [15:0] wheel_time;
  logic [15:0] crank_revs;
  logic [15:0] crank_time;
  logic [31:0] wheel_speed_mm_s;

  modport source (
    output valid, output status, output valid_flags, output wheel_revs,
    output wheel_time, output crank_revs, output crank_time,
    output wheel_speed_mm_s, input ready
  );
  modport sink (
    input valid, input status, input valid_flags, input wheel_revs,
    input wheel_time, input crank_revs, input crank_time,
    input wheel_speed_mm_s, output ready
  );
endinterface

FILE: hw/rtl/cscm_speed_div.sv
module cscm_speed_div (
  input  logic                            clk,
  input  logic                            rst,
  input  cscm_pkg::cscm_ctrl_t            ctrl,
  input  logic [cscm_pkg::REV_W-1:0]      drev,
  input  logic [cscm_pkg::DT_W-1:0]       dt,
  input  logic [cscm_pkg::CIRC_W-1:0]     circ,
  output cscm_pkg::cscm_sts_t             sts,
  output logic [cscm_pkg::QUO_W-1:0]      quo_next
);
  import cscm_pkg::*;

  localparam int HI_W = PROD_W + TIME_SHIFT - QUO_W;

  logic [REV_W-1:0]      drev_r;
  logic [DT_W-1:0]       dt_r;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     mul_res;
  logic [DT_W-1:0]       rem;
  logic [QUO_W-1:0]      quo;
  logic [STEP_CNT_W-1:0] cnt;
  logic [HI_W-1:0]       num_hi;
  logic [DT_W:0]         trial;
  logic [DT_W:0]         diff;
  logic                  take;

  assign mul_res = PROD_W'(drev_r) * PROD_W'(circ);

  // dividend is prod << 10; upper part must stay below dt for a 32-bit quotient
  assign num_hi   = prod[PROD_W-1 -: HI_W];
  assign trial    = {rem, quo[QUO_W-1]};
  assign diff     = trial - {1'b0, dt_r};
  assign take     = trial >= {1'b0, dt_r};
  assign quo_next = {quo[QUO_W-2:0], take};

  assign sts.dt_zero = (dt_r == '0);
  assign sts.ovf     = (num_hi >= HI_W'(dt_r));
  assign sts.last    = &cnt;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      drev_r <= drev;
      dt_r   <= dt;
    end
    if (ctrl.mul) begin
      prod <= mul_res;
    end
    if (ctrl.prime) begin
      rem <= num_hi[DT_W-1:0];
      quo <= {prod[QUO_W-TIME_SHIFT-1:0], {TIME_SHIFT{1'b0}}};
    end else if (ctrl.step) begin
      rem <= take ? diff[DT_W-1:0] : trial[DT_W-1:0];
      quo <= quo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.prime) begin
      cnt <= '0;
    end else if (ctrl.step) begin
      cnt <= cnt + 1'b1;
    end
  end

endmodule

FILE: hw/rtl/csc_measurement_parse_speed.sv
// Channel   Dir  Payload                                         Beat
// pkt       in   data_byte[7:0], last_byte                      one packet byte
// meas      out  status, valid_flags, wheel/crank revs & time,  one result per packet
//                wheel_speed_mm_s
// cfg       in   cfg_wr_en, cfg_wr_data[15:0]                   circumference write
//
// Each last byte starts a commit; with a wheel commit the sequencer goes on
// through the 32x16 multiply and a range check, then, unless the time delta is
// zero or the speed saturates, through 32 compare/subtract divider steps.
// pkt.ready is high only while the sequencer is idle; meas has its own output
// register, so a stalled result only holds the sequencer at its final state.
// rst is synchronous, active high; circumference resets to 2096 mm.
module csc_measurement_parse_speed (
  input  logic                          clk,
  input  logic                          rst,
  cscm_pkt_if.sink                      pkt,
  cscm_meas_if.source                   meas,
  input  logic                          cfg_wr_en,
  input  logic [cscm_pkg::CIRC_W-1:0]   cfg_wr_data
);
  import cscm_pkg::*;

  cscm_state_t state, state_next;
  cscm_ctrl_t  ctrl;
  cscm_sts_t   sts;

  logic [CIRC_W-1:0] wheel_circumference_mm;

  // packet assembly
  logic [3:0]        byte_position;
  logic [7:0]        packet_flags;
  logic [REV_W-1:0]  incoming_wheel_revs;
  logic [DT_W-1:0]   incoming_wheel_time;
  logic [15:0]       incoming_crank_revs;
  logic [DT_W-1:0]   incoming_crank_time;

  // committed samples
  logic [REV_W-1:0]  current_wheel_revs;
  logic [DT_W-1:0]   current_wheel_time;
  logic [15:0]       current_crank_revs;
  logic [DT_W-1:0]   current_crank_time;
  logic [REV_W-1:0]  previous_wheel_revs;
  logic [DT_W-1:0]   previous_wheel_time;
  logic [QUO_W-1:0]  speed_value;

  // pending result
  logic              res_status;
  logic [7:0]        res_flags;

  logic              pkt_acc;
  logic              out_load;
  logic              out_valid;
  logic              has_wheel;
  logic              has_crank;
  logic [3:0]        crank_at;
  logic [3:0]        crank_off;
  logic [3:0]        wrev_idx;
  logic              in_crank;
  logic              wheel_short;
  logic              wheel_commit;
  logic              crank_commit;
  logic [3:0]        crank_end;
  logic [QUO_W-1:0]  quo_next;

  assign pkt_acc  = pkt.valid & pkt.ready;
  assign out_load = (state == ST_WAIT) & (~out_valid | meas.ready);

  // byte capture decode (flags byte already stored once pos > 0)
  assign has_wheel = packet_flags[FLAG_WHEEL];
  assign has_crank = packet_flags[FLAG_CRANK];
  assign crank_at  = has_wheel ? CRANK_AT_WHEEL : CRANK_AT_NONE;
  assign crank_off = byte_position - crank_at;
  assign wrev_idx  = byte_position - 4'd1;
  assign in_crank  = has_crank & (byte_position >= crank_at) & (crank_off < 4'd4);

  // commit decode, valid in ST_COMMIT with byte_position = last byte index
  assign crank_end    = has_wheel ? CRANK_END_WHEEL : CRANK_END_NONE;
  assign wheel_short  = has_wheel & (byte_position < WHEEL_END);
  assign wheel_commit = has_wheel & ~wheel_short;
  assign crank_commit = has_crank & ~wheel_short & (byte_position >= crank_end);

  cscm_speed_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .drev     (incoming_wheel_revs - previous_wheel_revs),
    .dt       (incoming_wheel_time - previous_wheel_time),
    .circ     (wheel_circumference_mm),
    .sts      (sts),
    .quo_next (quo_next)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pkt_acc && pkt.last_byte) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: state_next = wheel_commit ? ST_MUL : ST_WAIT;
      ST_MUL:    state_next = ST_CHECK;
      ST_CHECK: begin
        state_next = (sts.dt_zero || sts.ovf) ? ST_WAIT : ST_DIV;
      end
      ST_DIV: begin
        if (sts.last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl      = '0;
    pkt.ready = 1'b0;
    unique case (state)
      ST_IDLE:   pkt.ready  = 1'b1;
      ST_COMMIT: ctrl.load  = wheel_commit;
      ST_MUL:    ctrl.mul   = 1'b1;
      ST_CHECK:  ctrl.prime = ~sts.dt_zero & ~sts.ovf;
      ST_DIV:    ctrl.step  = 1'b1;
      ST_WAIT:   ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_circumference_mm <= CIRC_RESET;
    end else if (cfg_wr_en) begin
      wheel_circumference_mm <= cfg_wr_data;
    end
  end

  // parser and commit state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= '0;
      packet_flags        <= '0;
      incoming_wheel_revs <= '0;
      incoming_wheel_time <= '0;
      incoming_crank_revs <= '0;
      incoming_crank_time <= '0;
      current_wheel_revs  <= '0;
      current_wheel_time  <= '0;
      current_crank_revs  <= '0;
      current_crank_time  <= '0;
      previous_wheel_revs <= '0;
      previous_wheel_time <= '0;
      speed_value         <= '0;
      res_status          <= 1'b0;
      res_flags           <= '0;
    end else begin
      if (pkt_acc) begin
        priority if (byte_position == POS_FLAGS) begin
          packet_flags <= pkt.data_byte;
        end else if (has_wheel && byte_position <= POS_WREV_LAST) begin
          incoming_wheel_revs[8*wrev_idx[1:0] +: 8] <= pkt.data_byte;
        end else if (has_wheel && byte_position == POS_WTIME_LO) begin
          incoming_wheel_time[7:0] <= pkt.data_byte;
        end else if (has_wheel && byte_position == POS_WTIME_HI) begin
          incoming_wheel_time[15:8] <= pkt.data_byte;
        end else if (in_crank) begin
          unique case (crank_off[1:0])
            CRANK_REV_LO:  incoming_crank_revs[7:0]  <= pkt.data_byte;
            CRANK_REV_HI:  incoming_crank_revs[15:8] <= pkt.data_byte;
            CRANK_TIME_LO: incoming_crank_time[7:0]  <= pkt.data_byte;
            CRANK_TIME_HI: incoming_crank_time[15:8] <= pkt.data_byte;
            default: ;
          endcase
        end else begin
        end
        // hold position of the last byte for the commit decode
        if (!pkt.last_byte && byte_position != POS_MAX) begin
          byte_position <= byte_position + 4'd1;
        end
      end

      if (state == ST_COMMIT) begin
        byte_position <= '0;
        res_status    <= wheel_short | (has_crank & ~crank_commit);
        res_flags     <= (wheel_short | (has_crank & ~crank_commit)) ? 8'h00 : packet_flags;
        if (wheel_commit) begin
          current_wheel_revs  <= incoming_wheel_revs;
          current_wheel_time  <= incoming_wheel_time;
          previous_wheel_revs <= incoming_wheel_revs;
          previous_wheel_time <= incoming_wheel_time;
        end
        if (crank_commit) begin
          current_crank_revs <= incoming_crank_revs;
          current_crank_time <= incoming_crank_time;
        end
      end

      if (state == ST_CHECK) begin
        if (sts.dt_zero) begin
          speed_value <= '0;
        end else if (sts.ovf) begin
          speed_value <= '1;
        end
      end
      if (state == ST_DIV && sts.last) begin
        speed_value <= quo_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (meas.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      meas.status           <= res_status;
      meas.valid_flags      <= res_flags;
      meas.wheel_revs       <= current_wheel_revs;
      meas.wheel_time       <= current_wheel_time;
      meas.crank_revs       <= current_crank_revs;
      meas.crank_time       <= current_crank_time;
      meas.wheel_speed_mm_s <= speed_value;
    end
  end

  assign meas.valid = out_valid;

`ifndef SYNTHESIS
  // a too-short wheel group must leave the committed wheel sample alone
  a_short_no_commit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT && wheel_short) |=> $stable(current_wheel_revs))
    else $error("wheel sample committed from a short packet");

  // byte counter restarts after every packet
  a_pos_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMMIT) |=> (byte_position == '0))
    else $error("byte position not cleared after packet end");

  // the divider runs without gaps until its final step
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && !sts.last) |=> (state == ST_DIV))
    else $error("division left early");

  // an error result never reports flags
  a_err_flags: assert property (@(posedge clk) disable iff (rst)
    (out_load && res_status) |=> (meas.valid && meas.valid_flags == 8'h00))
    else $error("flags reported on a short packet");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

// Checks the cycling speed and cadence parser against a cycle-free model
// kept right here. Packet bytes go in on pkt and one measurement comes back
// for every last byte. Each returned beat is compared field by field with
// the oldest prediction. The run goes through several wheel circumferences
// and three idle mixes, and it includes one long receiver stall.
module tb_top;
  import cscm_pkg::*;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;
  localparam int   TICKS_PER_S  = 1024;     // event times are in 1/1024 s
  localparam int   SETTLE_CYC   = 60;       // idle time before a register write
  localparam int   HOLD_CYC     = 400;      // long receiver stall
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   MAX_REPORTS  = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_beat_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  flags;
    logic [31:0] wheel_revs;
    logic [15:0] wheel_time;
    logic [15:0] crank_revs;
    logic [15:0] crank_time;
    logic [31:0] speed;
  } meas_t;

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CIRC_W-1:0] cfg_wr_data;

  cscm_pkt_if  pkt_ch();
  cscm_meas_if meas_ch();

  csc_measurement_parse_speed dut (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt_ch.sink),
    .meas        (meas_ch.source),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Stimulus store and run controls
  // ---------------------------------------------------------------------
  pkt_beat_t   byte_q[$];      // packet bytes waiting for the driver
  meas_t       meas_exp_q[$];  // predicted measurements, oldest first
  logic [7:0]  pkt_bytes[$];   // packet under construction

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req_cnt = 0;       // bump to request one long receiver stall
  int bytes_queued  = 0;
  int bytes_in      = 0;
  int meas_seen     = 0;
  int err_cnt       = 0;
  int cycle_cnt     = 0;
  int circ_settings = 1;       // the reset value counts as the first one
  bit pkt_taken     = 1'b0;    // a byte was accepted at the last rising edge

  // Content generator: keeps cumulative counters moving in small steps so
  // most speeds land in a sane range, with an occasional wild jump.
  logic [31:0] gen_wheel_revs = '0;
  logic [15:0] gen_wheel_time = '0;
  logic [15:0] gen_crank_revs = '0;
  logic [15:0] gen_crank_time = '0;

  // ---------------------------------------------------------------------
  // Parser model state
  // ---------------------------------------------------------------------
  logic [CIRC_W-1:0] circ_mm = CIRC_RESET;
  logic [3:0]        byte_pos = '0;
  logic [7:0]        pkt_flags = '0;
  logic [31:0]       asm_wheel_revs = '0;
  logic [15:0]       asm_wheel_time = '0;
  logic [15:0]       asm_crank_revs = '0;
  logic [15:0]       asm_crank_time = '0;
  logic [31:0]       cur_wheel_revs = '0;
  logic [15:0]       cur_wheel_time = '0;
  logic [15:0]       cur_crank_revs = '0;
  logic [15:0]       cur_crank_time = '0;
  logic [31:0]       prev_wheel_revs = '0;
  logic [15:0]       prev_wheel_time = '0;
  logic [31:0]       speed_mm_s = '0;

  // Speed from the new wheel sample against the previous one. Deltas wrap;
  // zero time delta gives zero; the quotient saturates at 32 bits.
  task automatic update_wheel_speed();
    logic [31:0] drev;
    logic [15:0] dt;
    logic [63:0] num;
    logic [63:0] quo;
    drev = cur_wheel_revs - prev_wheel_revs;
    dt   = cur_wheel_time - prev_wheel_time;
    if (dt == '0) begin
      speed_mm_s = '0;
    end else begin
      num = 64'(drev) * 64'(circ_mm) * 64'(TICKS_PER_S);
      quo = num / 64'(dt);
      speed_mm_s = (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    end
    prev_wheel_revs = cur_wheel_revs;
    prev_wheel_time = cur_wheel_time;
  endtask

  // One accepted byte: place it in the assembly registers, and on the last
  // byte commit whatever groups fit and predict the measurement.
  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic       has_wheel;
    logic       has_crank;
    logic [3:0] pos;
    logic [3:0] crank_at;
    logic [3:0] crank_end;
    logic [1:0] k;
    logic       ok;
    meas_t      m;
    pos       = byte_pos;
    has_wheel = pkt_flags[FLAG_WHEEL];
    crank_at  = has_wheel ? CRANK_AT_WHEEL : CRANK_AT_NONE;
    if (pos == POS_FLAGS) begin
      pkt_flags = b;
    end else if (has_wheel && pos <= POS_WREV_LAST) begin
      asm_wheel_revs[(pos - 1) * 8 +: 8] = b;
    end else if (has_wheel && pos == POS_WTIME_LO) begin
      asm_wheel_time[7:0] = b;
    end else if (has_wheel && pos == POS_WTIME_HI) begin
      asm_wheel_time[15:8] = b;
    end else if (pkt_flags[FLAG_CRANK] && pos >= crank_at && pos < crank_at + 4'd4) begin
      k = 2'(pos - crank_at);
      case (k)
        CRANK_REV_LO:  asm_crank_revs[7:0]  = b;
        CRANK_REV_HI:  asm_crank_revs[15:8] = b;
        CRANK_TIME_LO: asm_crank_time[7:0]  = b;
        default:       asm_crank_time[15:8] = b;
      endcase
    end

    if (!last) begin
      if (byte_pos != POS_MAX) byte_pos = byte_pos + 4'd1;
    end else begin
      // flags may have just been written by this very byte
      has_wheel = pkt_flags[FLAG_WHEEL];
      has_crank = pkt_flags[FLAG_CRANK];
      ok = 1'b1;
      if (has_wheel) begin
        if (pos < WHEEL_END) begin
          ok = 1'b0;
        end else begin
          cur_wheel_revs = asm_wheel_revs;
          cur_wheel_time = asm_wheel_time;
          update_wheel_speed();
        end
      end
      if (ok && has_crank) begin
        crank_end = has_wheel ? CRANK_END_WHEEL : CRANK_END_NONE;
        if (pos < crank_end) begin
          ok = 1'b0;
        end else begin
          cur_crank_revs = asm_crank_revs;
          cur_crank_time = asm_crank_time;
        end
      end
      byte_pos     = POS_FLAGS;
      m.status     = ok ? STATUS_OK : STATUS_SHORT;
      m.flags      = ok ? pkt_flags : 8'h00;
      m.wheel_revs = cur_wheel_revs;
      m.wheel_time = cur_wheel_time;
      m.crank_revs = cur_crank_revs;
      m.crank_time = cur_crank_time;
      m.speed      = speed_mm_s;
      meas_exp_q.push_back(m);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      if (err_cnt <= MAX_REPORTS)
        $display("t=%0t measurement %0d %s: expected %0h, got %0h",
                 $realtime, meas_seen, fname, want, got);
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: input beats feed the model, output beats are checked.
  // Sampled at the rising edge, before the block's registers move.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    meas_t got;
    meas_t want;
    pkt_taken = !rst && pkt_ch.valid && pkt_ch.ready;
    if (pkt_taken) begin
      parse_byte(pkt_ch.data_byte, pkt_ch.last_byte);
      bytes_in++;
    end
    if (!rst && meas_ch.valid && meas_ch.ready) begin
      got.status     = meas_ch.status;
      got.flags      = meas_ch.valid_flags;
      got.wheel_revs = meas_ch.wheel_revs;
      got.wheel_time = meas_ch.wheel_time;
      got.crank_revs = meas_ch.crank_revs;
      got.crank_time = meas_ch.crank_time;
      got.speed      = meas_ch.wheel_speed_mm_s;
      if (meas_exp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("t=%0t unexpected measurement beat, status %0b flags %0h",
                   $realtime, got.status, got.flags);
      end else begin
        want = meas_exp_q.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("valid_flags", 32'(want.flags), 32'(got.flags));
        check_field("wheel_revs", want.wheel_revs, got.wheel_revs);
        check_field("wheel_time", 32'(want.wheel_time), 32'(got.wheel_time));
        check_field("crank_revs", 32'(want.crank_revs), 32'(got.crank_revs));
        check_field("crank_time", 32'(want.crank_time), 32'(got.crank_time));
        check_field("wheel_speed_mm_s", want.speed, got.speed);
      end
      meas_seen++;
    end
  end

  // Watchdog
  always @(posedge clk) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("t=%0t timeout: %0d bytes queued, %0d measurements pending",
               $realtime, byte_q.size(), meas_exp_q.size());
      $display("csc_measurement_parse_speed: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Byte driver: changes at the falling edge. An offered byte holds until
  // it is taken; otherwise a new byte is offered unless the sender idles.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : pkt_driver
    pkt_beat_t nxt;
    if (!(pkt_ch.valid && !pkt_taken)) begin
      if (!rst && byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        pkt_ch.valid     <= 1'b1;
        pkt_ch.data_byte <= nxt.data;
        pkt_ch.last_byte <= nxt.last;
      end else begin
        pkt_ch.valid     <= 1'b0;
        pkt_ch.data_byte <= 8'($urandom);
        pkt_ch.last_byte <= 1'($urandom);
      end
    end
  end

  // Receiver ready: random back-pressure, plus a long hold when asked. The
  // hold is counted here so the sender keeps offering meanwhile.
  int stall_seen = 0;
  int hold_left  = 0;
  always @(negedge clk) begin : meas_ready_driver
    if (stall_seen != stall_req_cnt) begin
      stall_seen     <= stall_req_cnt;
      hold_left      <= HOLD_CYC;
      meas_ch.ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left      <= hold_left - 1;
      meas_ch.ready  <= 1'b0;
    end else begin
      meas_ch.ready  <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Packet building
  // ---------------------------------------------------------------------
  task automatic send_packet();
    pkt_beat_t bt;
    for (int i = 0; i < pkt_bytes.size(); i++) begin
      bt.data = pkt_bytes[i];
      bt.last = (i == pkt_bytes.size() - 1);
      byte_q.push_back(bt);
    end
    bytes_queued += pkt_bytes.size();
    pkt_bytes.delete();
  endtask

  // Mostly well-formed packets with moving counters; the rest are cut
  // short, padded past the byte position limit, or plain noise.
  task automatic random_packet();
    int         kind;
    int         cut;
    int         extra;
    logic [7:0] flags;
    kind  = $urandom_range(99);
    flags = 8'($urandom_range(3));
    if ($urandom_range(3) == 0) flags[7:2] = 6'($urandom);
    pkt_bytes.push_back(flags);
    if (flags[FLAG_WHEEL]) begin
      if ($urandom_range(9) == 0) gen_wheel_revs = $urandom;
      else gen_wheel_revs += $urandom_range(6);
      if ($urandom_range(9) == 0) gen_wheel_time = 16'($urandom);
      else gen_wheel_time += 16'($urandom_range(2048));
      for (int i = 0; i < 4; i++) pkt_bytes.push_back(gen_wheel_revs[i * 8 +: 8]);
      pkt_bytes.push_back(gen_wheel_time[7:0]);
      pkt_bytes.push_back(gen_wheel_time[15:8]);
    end
    if (flags[FLAG_CRANK]) begin
      if ($urandom_range(9) == 0) gen_crank_revs = 16'($urandom);
      else gen_crank_revs += 16'($urandom_range(3));
      if ($urandom_range(9) == 0) gen_crank_time = 16'($urandom);
      else gen_crank_time += 16'($urandom_range(1500));
      pkt_bytes.push_back(gen_crank_revs[7:0]);
      pkt_bytes.push_back(gen_crank_revs[15:8]);
      pkt_bytes.push_back(gen_crank_time[7:0]);
      pkt_bytes.push_back(gen_crank_time[15:8]);
    end
    if (kind < 15) begin
      // truncated
      cut = $urandom_range(pkt_bytes.size(), 1);
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end else if (kind < 27) begin
      // trailing junk, sometimes past position 15
      extra = $urandom_range(12, 1);
      repeat (extra) pkt_bytes.push_back(8'($urandom));
    end else if (kind < 33) begin
      // noise of any length
      pkt_bytes.delete();
      extra = $urandom_range(20, 1);
      repeat (extra) pkt_bytes.push_back(8'($urandom));
    end
    send_packet();
  endtask

  task automatic random_bytes(input int n);
    int target;
    target = bytes_queued + n;
    while (bytes_queued < target) random_packet();
  endtask

  // Sender stops and waits for every measurement, then lets the block
  // settle so it is idle before any register write.
  task automatic drain_and_settle();
    while (byte_q.size() != 0 || pkt_ch.valid || meas_exp_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic set_circumference(input logic [CIRC_W-1:0] mm);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mm;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    circ_mm     = mm;
    circ_settings++;
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = CIRC_RESET;
    pkt_ch.valid      = 1'b0;
    pkt_ch.data_byte  = '0;
    pkt_ch.last_byte  = 1'b0;
    meas_ch.ready     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Phase 0: reset circumference, busy sender, lazy receiver.
    send_idle_pct = 35;
    recv_idle_pct = 66;
    // no groups, only unknown flag bits
    pkt_bytes = {8'hFC};
    send_packet();
    // crank flag but only one crank byte follows
    pkt_bytes = {8'h02, 8'h11};
    send_packet();
    // first wheel sample against the zero reset values, saturating speed
    pkt_bytes = {8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet();
    // same sample again: zero time delta
    pkt_bytes = {8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_packet();
    // wheel fits, crank cut short; revs and time wrap
    pkt_bytes = {8'h03, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00, 8'h04, 8'h7B};
    send_packet();
    // crank only, complete
    pkt_bytes = {8'h02, 8'h34, 8'h12, 8'h78, 8'h56};
    send_packet();
    random_bytes(130);
    drain_and_settle();

    // Phase 1: smallest nonzero circumference, with the long receiver hold while
    // bytes keep coming, so the input backs up.
    set_circumference(16'd1);
    random_bytes(180);
    stall_req_cnt++;
    drain_and_settle();

    // Phases 2 and 3: idle mix reversed.
    send_idle_pct = 66;
    recv_idle_pct = 35;
    set_circumference(16'hFFFF);
    random_bytes(180);
    drain_and_settle();
    set_circumference(16'($urandom_range(16'hFFFF, 1)));
    random_bytes(180);
    drain_and_settle();

    // Phases 4 and 5: no idling; zero circumference, then back to default.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_circumference(16'd0);
    random_bytes(120);
    drain_and_settle();
    set_circumference(CIRC_RESET);
    random_bytes(120);
    drain_and_settle();

    $display("Covered %0d packet bytes and %0d measurements over %0d circumference values,",
             bytes_in, meas_seen, circ_settings);
    $display("with short, padded and noisy packets and a long output stall; %0d field errors.",
             err_cnt);
    if (err_cnt == 0) begin
      $display("csc_measurement_parse_speed: match");
    end else begin
      $display("csc_measurement_parse_speed: mismatch");
    end
    $finish;
  end

endmodule
